// ===== hdl/tfs_pkg.sv =====
package tfs_pkg;

	localparam int PIX_W   = 16;
	localparam int CFG_W   = 11;
	localparam int CFG_A_W = 3;
	localparam int POS_W   = 10;
	localparam int GEO_W   = 14;
	localparam int SUM_W   = 36;
	localparam int CNT_W   = 21;
	localparam int QUO_W   = 16;
	localparam int STEP_W  = $clog2(QUO_W);

	localparam logic [CNT_W-1:0] PIXEL_CAP = CNT_W'(1048576);
	localparam logic [PIX_W-1:0] FULL16    = 16'hFFFF;

	localparam logic [CFG_A_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_A_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_A_W-1:0] REG_ROI_LEFT     = 3'd2;
	localparam logic [CFG_A_W-1:0] REG_ROI_TOP      = 3'd3;
	localparam logic [CFG_A_W-1:0] REG_ROI_COLS     = 3'd4;
	localparam logic [CFG_A_W-1:0] REG_ROI_ROWS     = 3'd5;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_WAIT
	} tfs_state_t;

	typedef struct packed {
		logic take;
		logic snap;
		logic div_step;
		logic load;
	} tfs_cmd_t;

endpackage

// ===== hdl/tfs_if.sv =====
interface tfs_pix_if;
	import tfs_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             frame_end;
	modport source(output valid, pixel_value, frame_end, input ready);
	modport sink(input valid, pixel_value, frame_end, output ready);
endinterface

interface tfs_res_if;
	import tfs_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] whole_min;
	logic [PIX_W-1:0] whole_max;
	logic [PIX_W-1:0] whole_mean;
	logic [POS_W-1:0] hot_col;
	logic [POS_W-1:0] hot_row;
	logic [PIX_W-1:0] hot_value;
	logic             roi_ok;
	logic [PIX_W-1:0] roi_min;
	logic [PIX_W-1:0] roi_max;
	logic [PIX_W-1:0] roi_mean;
	modport source(output valid, whole_min, whole_max, whole_mean, hot_col, hot_row,
		hot_value, roi_ok, roi_min, roi_max, roi_mean, input ready);
	modport sink(input valid, whole_min, whole_max, whole_mean, hot_col, hot_row,
		hot_value, roi_ok, roi_min, roi_max, roi_mean, output ready);
endinterface

interface tfs_cfg_if;
	import tfs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CFG_A_W-1:0] index;
	logic [CFG_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/tfs_div.sv =====
module tfs_div
	import tfs_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient
);

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic             fits;

	// Quotient is known to fit in QUO_W bits, so start at the top quotient bit.
	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

// ===== hdl/tfs_dp.sv =====
module tfs_dp
	import tfs_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tfs_cmd_t     cmd,
	input  logic [PIX_W-1:0] pixel_value,
	tfs_cfg_if.sink      cfg,
	output logic [PIX_W-1:0] whole_min,
	output logic [PIX_W-1:0] whole_max,
	output logic [PIX_W-1:0] whole_mean,
	output logic [POS_W-1:0] hot_col,
	output logic [POS_W-1:0] hot_row,
	output logic [PIX_W-1:0] hot_value,
	output logic             roi_ok,
	output logic [PIX_W-1:0] roi_min,
	output logic [PIX_W-1:0] roi_max,
	output logic [PIX_W-1:0] roi_mean
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [CFG_W-1:0] frame_width_q, frame_height_q, roi_cols_q, roi_rows_q;
	logic [POS_W-1:0] roi_left_q, roi_top_q;

	logic [COL_W-1:0] col_q, best_col_q, res_col_q;
	logic [ROW_W-1:0] row_q, best_row_q, res_row_q;
	logic [PIX_W-1:0] run_min_q, run_max_q, best_q, box_min_q, box_max_q;
	logic [SUM_W-1:0] run_sum_q, box_sum_q;
	logic [CNT_W-1:0] run_cnt_q, box_cnt_q;

	logic [PIX_W-1:0] res_min_q, res_max_q, res_hot_q, res_bmin_q, res_bmax_q;
	logic             res_ok_q;

	logic [GEO_W-1:0] w_eff, h_eff, fw, fh, col_x, row_x;
	logic             in_box, box_valid, hotter;
	logic [PIX_W-1:0] nxt_min, nxt_max, nxt_bmin, nxt_bmax;
	logic [SUM_W-1:0] nxt_sum, nxt_bsum;
	logic [CNT_W-1:0] nxt_cnt, nxt_bcnt;
	logic [QUO_W-1:0] whole_quo, box_quo;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(256);
			frame_height_q <= CFG_W'(192);
			roi_left_q     <= '0;
			roi_top_q      <= '0;
			roi_cols_q     <= '0;
			roi_rows_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data;
				REG_ROI_LEFT:     roi_left_q     <= cfg.data[POS_W-1:0];
				REG_ROI_TOP:      roi_top_q      <= cfg.data[POS_W-1:0];
				REG_ROI_COLS:     roi_cols_q     <= cfg.data;
				REG_ROI_ROWS:     roi_rows_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// Effective geometry: zero acts as one, oversize clamps to the maximum.
	always_comb begin
		fw = GEO_W'(frame_width_q);
		fh = GEO_W'(frame_height_q);
		if (fw == '0) w_eff = GEO_W'(1);
		else if (fw > GEO_W'(MAX_WIDTH)) w_eff = GEO_W'(MAX_WIDTH);
		else w_eff = fw;
		if (fh == '0) h_eff = GEO_W'(1);
		else if (fh > GEO_W'(MAX_HEIGHT)) h_eff = GEO_W'(MAX_HEIGHT);
		else h_eff = fh;
	end

	assign col_x = GEO_W'(col_q);
	assign row_x = GEO_W'(row_q);

	assign in_box = (col_x >= GEO_W'(roi_left_q)) &&
		(col_x < GEO_W'(roi_left_q) + GEO_W'(roi_cols_q)) &&
		(row_x >= GEO_W'(roi_top_q)) &&
		(row_x < GEO_W'(roi_top_q) + GEO_W'(roi_rows_q));

	assign box_valid = (roi_cols_q != '0) && (roi_rows_q != '0) &&
		(GEO_W'(roi_left_q) + GEO_W'(roi_cols_q) <= w_eff) &&
		(GEO_W'(roi_top_q) + GEO_W'(roi_rows_q) <= h_eff);

	assign hotter = pixel_value > best_q;

	always_comb begin
		nxt_min  = (pixel_value < run_min_q) ? pixel_value : run_min_q;
		nxt_max  = (pixel_value > run_max_q) ? pixel_value : run_max_q;
		nxt_sum  = run_sum_q;
		nxt_cnt  = run_cnt_q;
		if (run_cnt_q < PIXEL_CAP) begin
			nxt_sum = run_sum_q + SUM_W'(pixel_value);
			nxt_cnt = run_cnt_q + 1'b1;
		end
		nxt_bmin = box_min_q;
		nxt_bmax = box_max_q;
		nxt_bsum = box_sum_q;
		nxt_bcnt = box_cnt_q;
		if (in_box) begin
			if (pixel_value < box_min_q) nxt_bmin = pixel_value;
			if (pixel_value > box_max_q) nxt_bmax = pixel_value;
			if (box_cnt_q < PIXEL_CAP) begin
				nxt_bsum = box_sum_q + SUM_W'(pixel_value);
				nxt_bcnt = box_cnt_q + 1'b1;
			end
		end
	end

	// Frame accumulators: advance on every pixel but the last, which clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			run_min_q  <= FULL16;
			run_max_q  <= '0;
			run_sum_q  <= '0;
			run_cnt_q  <= '0;
			best_q     <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
			box_min_q  <= FULL16;
			box_max_q  <= '0;
			box_sum_q  <= '0;
			box_cnt_q  <= '0;
		end else if (cmd.take) begin
			if (cmd.snap) begin
				col_q      <= '0;
				row_q      <= '0;
				run_min_q  <= FULL16;
				run_max_q  <= '0;
				run_sum_q  <= '0;
				run_cnt_q  <= '0;
				best_q     <= '0;
				best_col_q <= '0;
				best_row_q <= '0;
				box_min_q  <= FULL16;
				box_max_q  <= '0;
				box_sum_q  <= '0;
				box_cnt_q  <= '0;
			end else begin
				run_min_q <= nxt_min;
				run_max_q <= nxt_max;
				run_sum_q <= nxt_sum;
				run_cnt_q <= nxt_cnt;
				box_min_q <= nxt_bmin;
				box_max_q <= nxt_bmax;
				box_sum_q <= nxt_bsum;
				box_cnt_q <= nxt_bcnt;
				if (hotter) begin
					best_q     <= pixel_value;
					best_col_q <= col_q;
					best_row_q <= row_q;
				end
				if (col_x + GEO_W'(1) >= w_eff) begin
					col_q <= '0;
					if (row_x + GEO_W'(1) < GEO_W'(MAX_HEIGHT)) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Snapshot of the finished frame, held while the means are worked out.
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			res_min_q  <= nxt_min;
			res_max_q  <= nxt_max;
			res_hot_q  <= hotter ? pixel_value : best_q;
			res_col_q  <= hotter ? col_q : best_col_q;
			res_row_q  <= hotter ? row_q : best_row_q;
			res_ok_q   <= box_valid && (nxt_bcnt != '0);
			res_bmin_q <= nxt_bmin;
			res_bmax_q <= nxt_bmax;
		end
	end

	tfs_div u_whole_div (
		.clk      (clk),
		.load     (cmd.snap),
		.step     (cmd.div_step),
		.dividend (nxt_sum),
		.divisor  (nxt_cnt),
		.quotient (whole_quo)
	);

	tfs_div u_box_div (
		.clk      (clk),
		.load     (cmd.snap),
		.step     (cmd.div_step),
		.dividend (nxt_bsum),
		.divisor  (nxt_bcnt),
		.quotient (box_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			whole_min  <= res_min_q;
			whole_max  <= res_max_q;
			whole_mean <= whole_quo;
			hot_col    <= POS_W'(res_col_q);
			hot_row    <= POS_W'(res_row_q);
			hot_value  <= res_hot_q;
			roi_ok     <= res_ok_q;
			roi_min    <= res_ok_q ? res_bmin_q : '0;
			roi_max    <= res_ok_q ? res_bmax_q : '0;
			roi_mean   <= res_ok_q ? box_quo : '0;
		end
	end

endmodule

// ===== hdl/tfs_ctrl.sv =====
module tfs_ctrl
	import tfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output tfs_cmd_t cmd
);

	tfs_state_t        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					cmd.snap  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) state_nxt = ST_WAIT;
			end
			ST_WAIT: begin
				if (!out_full_q || out_ready) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			default: state_nxt = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.snap) step_q <= STEP_W'(QUO_W-1);
			else if (cmd.div_step) step_q <= step_q - 1'b1;
			if (cmd.load) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

	assign out_valid = out_full_q;

endmodule

// ===== hdl/thermal_frame_statistics_core.sv =====
// A result is offered once the dividers have formed both means and the output register is loaded.
// Throughput: one pixel per cycle within a frame; after the last pixel the input
// stalls while the 16-step shift-subtract dividers form both means, and
// longer while an earlier result still waits to be taken.
// Reset: arst_n clears the controller, the frame accumulators and the
// configuration registers (width 256, height 192, empty rectangle).
module thermal_frame_statistics_core
	import tfs_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	tfs_pix_if.sink    pix,
	tfs_res_if.source  res,
	tfs_cfg_if.sink    cfg
);

	tfs_cmd_t cmd;
	logic     in_ready;
	logic     out_valid;

	// Controller: accept pixels, then sequence the divide and the output load.
	tfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_last   (pix.frame_end),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	assign pix.ready = in_ready;
	assign res.valid = out_valid;

	// Datapath: statistics, snapshot, dividers and the output register.
	// The output register lets a new frame stream in while a result waits.
	tfs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pixel_value (pix.pixel_value),
		.cfg         (cfg),
		.whole_min   (res.whole_min),
		.whole_max   (res.whole_max),
		.whole_mean  (res.whole_mean),
		.hot_col     (res.hot_col),
		.hot_row     (res.hot_row),
		.hot_value   (res.hot_value),
		.roi_ok      (res.roi_ok),
		.roi_min     (res.roi_min),
		.roi_max     (res.roi_max),
		.roi_mean    (res.roi_mean)
	);

	// Never overwrite a result that has not been taken.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!res.valid || res.ready))
		else $error("output register overwritten while full");

	// Input stalls while the means are computed.
	a_stall_div: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && pix.frame_end) |=> !pix.ready)
		else $error("pixel accepted during divide");

	// Divide steps and pixel intake never overlap.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take && cmd.div_step))
		else $error("pixel intake during divide step");

	// A result is presented right after a load.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> res.valid)
		else $error("load did not present a result");

endmodule

// ===== tb/thermal_frame_statistics_core_test.sv =====
module thermal_frame_statistics_core_test;
	import tfs_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	// Worst case is every pixel behind a long gap and every frame behind a long
	// result stall plus the divide time; several times over.
	localparam int CYCLE_LIMIT = 500000;
	// Time for the result to come back after the frame_end transaction, with margin.
	localparam int SETTLE_CYCLES = 24;
	// Keep the pending pixel queue short.
	localparam int BACKLOG_DEPTH = 4096;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             last;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] whole_min, whole_max, whole_mean;
		logic [POS_W-1:0] hot_col, hot_row;
		logic [PIX_W-1:0] hot_value;
		logic             roi_ok;
		logic [PIX_W-1:0] roi_min, roi_max, roi_mean;
	} frame_stats_t;

	logic clk = 1'b0;
	logic arst_n;

	tfs_pix_if pix();
	tfs_res_if res();
	tfs_cfg_if cfg();

	thermal_frame_statistics_core #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.res   (res),
		.cfg   (cfg)
	);

	always #5 clk = ~clk;

	// Pixels waiting for the driver, and frame statistics waiting for the block.
	pixel_t       pixel_backlog[$];
	frame_stats_t expected_stats[$];

	int error_count = 0;
	int cycle_count = 0;
	// Set per phase: when high, neither side inserts gaps.
	bit quiet_stretch = 1'b0;

	// Shadow copy of the configuration registers.
	logic [CFG_W-1:0] shadow_width, shadow_height, shadow_cols, shadow_rows;
	logic [POS_W-1:0] shadow_left, shadow_top;

	// Predicted frame accumulators.
	logic [POS_W-1:0] scan_col, scan_row;
	logic [PIX_W-1:0] frame_lo, frame_hi, box_lo, box_hi;
	logic [SUM_W-1:0] frame_acc, box_acc;
	logic [CNT_W-1:0] frame_cnt, box_cnt;
	logic [PIX_W-1:0] peak_value;
	logic [POS_W-1:0] peak_col, peak_row;

	// Zero acts as one, anything past the maximum acts as the maximum.
	function automatic int limit_dim(int raw, int top);
		if (raw == 0)
			return 1;
		if (raw > top)
			return top;
		return raw;
	endfunction

	function automatic void restart_frame();
		scan_col   = '0;
		scan_row   = '0;
		frame_lo   = FULL16;
		frame_hi   = '0;
		frame_acc  = '0;
		frame_cnt  = '0;
		peak_value = '0;
		peak_col   = '0;
		peak_row   = '0;
		box_lo     = FULL16;
		box_hi     = '0;
		box_acc    = '0;
		box_cnt    = '0;
	endfunction

	// Fold one accepted pixel into the frame statistics; on the last pixel of
	// the frame, queue the statistics the block must report and start over.
	function automatic void accumulate_pixel(logic [PIX_W-1:0] v, logic last);
		int           w, h, col, row;
		logic         in_box, box_valid, ok;
		logic [SUM_W-1:0] quot;
		frame_stats_t s;
		w   = limit_dim(shadow_width, MAX_WIDTH);
		h   = limit_dim(shadow_height, MAX_HEIGHT);
		col = scan_col;
		row = scan_row;

		if (v < frame_lo)
			frame_lo = v;
		if (v > frame_hi)
			frame_hi = v;
		// Past the count cap the sum freezes, min and max keep tracking.
		if (frame_cnt < PIXEL_CAP) begin
			frame_acc += v;
			frame_cnt++;
		end
		// Strictly greater only: ties keep the first hot pixel in raster order.
		if (v > peak_value) begin
			peak_value = v;
			peak_col   = POS_W'(col);
			peak_row   = POS_W'(row);
		end

		in_box = col >= shadow_left && col < shadow_left + shadow_cols &&
			row >= shadow_top && row < shadow_top + shadow_rows;
		if (in_box) begin
			if (v < box_lo)
				box_lo = v;
			if (v > box_hi)
				box_hi = v;
			if (box_cnt < PIXEL_CAP) begin
				box_acc += v;
				box_cnt++;
			end
		end

		// Wrap the column at the row end; the row saturates at the last one.
		if (col + 1 >= w) begin
			scan_col = '0;
			if (row + 1 < MAX_HEIGHT)
				scan_row = POS_W'(row + 1);
		end else begin
			scan_col = POS_W'(col + 1);
		end

		if (!last)
			return;

		box_valid = shadow_cols != 0 && shadow_rows != 0 &&
			shadow_left + shadow_cols <= w && shadow_top + shadow_rows <= h;
		ok = box_valid && box_cnt != 0;

		s.whole_min = frame_lo;
		s.whole_max = frame_hi;
		quot        = frame_cnt != 0 ? frame_acc / frame_cnt : '0;
		s.whole_mean = quot[PIX_W-1:0];
		s.hot_col   = peak_col;
		s.hot_row   = peak_row;
		s.hot_value = peak_value;
		s.roi_ok    = ok;
		s.roi_min   = ok ? box_lo : '0;
		s.roi_max   = ok ? box_hi : '0;
		quot        = ok ? box_acc / box_cnt : '0;
		s.roi_mean  = quot[PIX_W-1:0];
		expected_stats.push_back(s);
		restart_frame();
	endfunction

	function automatic void check_field(string label, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_stats(frame_stats_t got);
		frame_stats_t want;
		if (expected_stats.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual whole_min %0d whole_max %0d",
				$time, got.whole_min, got.whole_max);
			error_count++;
			return;
		end
		want = expected_stats.pop_front();
		check_field("whole_min", want.whole_min, got.whole_min);
		check_field("whole_max", want.whole_max, got.whole_max);
		check_field("whole_mean", want.whole_mean, got.whole_mean);
		check_field("hot_col", want.hot_col, got.hot_col);
		check_field("hot_row", want.hot_row, got.hot_row);
		check_field("hot_value", want.hot_value, got.hot_value);
		check_field("roi_ok", want.roi_ok, got.roi_ok);
		check_field("roi_min", want.roi_min, got.roi_min);
		check_field("roi_max", want.roi_max, got.roi_max);
		check_field("roi_mean", want.roi_mean, got.roi_mean);
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int draw_gap();
		int roll;
		if (quiet_stretch)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Pixel driver: predict on each accepted transaction, then offer the next
	// pixel once the current one is gone.
	int source_hold = 0;

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_t next_pixel;
		if (!arst_n) begin
			pix.valid   <= 1'b0;
			source_hold = 0;
		end else begin
			if (pix.valid && pix.ready)
				accumulate_pixel(pix.pixel_value, pix.frame_end);
			if (!pix.valid || pix.ready) begin
				if (source_hold > 0) begin
					source_hold--;
					pix.valid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					next_pixel = pixel_backlog.pop_front();
					pix.valid       <= 1'b1;
					pix.pixel_value <= next_pixel.value;
					pix.frame_end   <= next_pixel.last;
					source_hold = draw_gap();
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted transaction, stall ready at random.
	int sink_hold = 0;

	always @(posedge clk or negedge arst_n) begin : result_monitor
		frame_stats_t observed;
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (res.valid && res.ready) begin
				observed.whole_min  = res.whole_min;
				observed.whole_max  = res.whole_max;
				observed.whole_mean = res.whole_mean;
				observed.hot_col    = res.hot_col;
				observed.hot_row    = res.hot_row;
				observed.hot_value  = res.hot_value;
				observed.roi_ok     = res.roi_ok;
				observed.roi_min    = res.roi_min;
				observed.roi_max    = res.roi_max;
				observed.roi_mean   = res.roi_mean;
				check_stats(observed);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				sink_hold = draw_gap();
			end
		end
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Hold off while the backlog drains and the pixel queue throttles.
	task automatic push_pixel(input logic [PIX_W-1:0] value, input logic last);
		pixel_t p;
		while (pixel_backlog.size() >= BACKLOG_DEPTH)
			@(posedge clk);
		p.value = value;
		p.last  = last;
		pixel_backlog.push_back(p);
	endtask

	task automatic push_frame(input int unsigned values[]);
		foreach (values[k])
			push_pixel(PIX_W'(values[k]), k == values.size() - 1);
	endtask

	// Wait until every pixel went out and every frame result came back, then
	// give the block its latency to settle.
	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pix.valid || expected_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
		REG_FRAME_WIDTH:  shadow_width  = val;
		REG_FRAME_HEIGHT: shadow_height = val;
		REG_ROI_LEFT:     shadow_left   = val[POS_W-1:0];
		REG_ROI_TOP:      shadow_top    = val[POS_W-1:0];
		REG_ROI_COLS:     shadow_cols   = val;
		REG_ROI_ROWS:     shadow_rows   = val;
		default: ;
		endcase
	endtask

	task automatic reconfigure(input int fw, input int fh, input int rl, input int rt,
		input int rc, input int rr);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(fw));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
		write_reg(REG_ROI_LEFT, CFG_W'(rl));
		write_reg(REG_ROI_TOP, CFG_W'(rt));
		write_reg(REG_ROI_COLS, CFG_W'(rc));
		write_reg(REG_ROI_ROWS, CFG_W'(rr));
	endtask

	// Pick a geometry: mostly small frames with a rectangle inside, sometimes
	// out-of-range sizes, empty, overhanging or fully random rectangles.
	task automatic pick_random_geometry();
		int fw, fh, ew, eh, rl, rt, rc, rr, pick;
		pick = $urandom_range(0, 9);
		case (pick)
		0: fw = 0;
		1: fw = 2047;
		2: fw = 1024;
		default: fw = $urandom_range(1, 12);
		endcase
		pick = $urandom_range(0, 9);
		case (pick)
		0: fh = 0;
		1: fh = 2047;
		default: fh = $urandom_range(1, 8);
		endcase
		ew = limit_dim(fw, MAX_WIDTH);
		eh = limit_dim(fh, MAX_HEIGHT);
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			rl = $urandom_range(0, ew - 1);
			rc = $urandom_range(1, ew - rl);
			rt = $urandom_range(0, eh - 1);
			rr = $urandom_range(1, eh - rt);
		end else if (pick == 7) begin
			rl = $urandom_range(0, 1023);
			rt = $urandom_range(0, 1023);
			rc = $urandom_range(0, 2047);
			rr = $urandom_range(0, 2047);
		end else if (pick == 8) begin
			rl = $urandom_range(0, ew - 1);
			rt = $urandom_range(0, eh - 1);
			rc = $urandom_range(0, 1) ? 0 : 1;
			rr = rc == 0 ? 1 : 0;
		end else begin
			// Overhang by one column or one row.
			rl = $urandom_range(0, ew - 1);
			rt = $urandom_range(0, eh - 1);
			rc = ew - rl + $urandom_range(0, 1);
			rr = eh - rt + (rc == ew - rl ? 1 : 0);
		end
		reconfigure(fw, fh, rl, rt, rc, rr);
	endtask

	// Queue whole frames of random length and content: all-zero, constant
	// (ties everywhere), tiny values, or full range with extremes mixed in.
	// The last frame is cut short so the phase sends exactly its budget.
	task automatic queue_random_frames(input int budget);
		int remaining, len, style, k;
		logic [PIX_W-1:0] base, v;
		remaining = budget;
		while (remaining > 0) begin
			len   = $urandom_range(1, 48);
			if (len > remaining)
				len = remaining;
			style = $urandom_range(0, 9);
			base  = PIX_W'($urandom);
			for (k = 0; k < len; k++) begin
				case (style)
				0: v = '0;
				1: v = base;
				2, 3: v = PIX_W'($urandom_range(0, 15));
				default: begin
					v = PIX_W'($urandom);
					if ($urandom_range(0, 15) == 0)
						v = $urandom_range(0, 1) ? FULL16 : '0;
				end
				endcase
				push_pixel(v, k == len - 1);
			end
			remaining -= len;
		end
	endtask

	initial begin
		int n;
		arst_n          = 1'b0;
		pix.valid       = 1'b0;
		pix.pixel_value = '0;
		pix.frame_end   = 1'b0;
		res.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_FRAME_WIDTH;
		cfg.data        = '0;
		shadow_width    = CFG_W'(256);
		shadow_height   = CFG_W'(192);
		shadow_left     = '0;
		shadow_top      = '0;
		shadow_cols     = '0;
		shadow_rows     = '0;
		restart_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry, empty rectangle: all-zero single-pixel frame, then a
		// tie on the hottest value and alternating bit patterns.
		push_frame('{0});
		push_frame('{16'h5555, 16'hAAAA, 16'hAAAA});

		// Width zero acts as one column, so each pixel opens a new row. First a
		// frame that ends before the rectangle, then one that crosses it.
		reconfigure(0, 2047, 0, 2, 1, 3);
		push_frame('{7, 9});
		push_frame('{100, 0, 65535, 7, 65535});

		// Oversized width, rectangle at the far column never reached.
		reconfigure(2047, 1, 1023, 0, 1, 1);
		push_frame('{3, 65535, 1, 0});

		// Rectangle hanging off the frame in both directions.
		reconfigure(3, 2, 2, 1023, 2, 2047);
		push_frame('{40000, 2, 65535, 17});

		// Small rectangle inside a small frame, with ties at full scale.
		reconfigure(4, 3, 1, 1, 2, 2);
		push_frame('{5, 65535, 8, 12, 0, 65535, 65535, 1});

		// Random phases: new geometry, random gap pattern, whole frames.
		for (n = 0; n < 10; n++) begin
			pick_random_geometry();
			quiet_stretch = $urandom_range(0, 3) == 0;
			queue_random_frames(62);
		end

		wait_idle();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== thermal_frame_statistics_core.f =====
hdl/tfs_pkg.sv
hdl/tfs_if.sv
hdl/tfs_div.sv
hdl/tfs_dp.sv
hdl/tfs_ctrl.sv
hdl/thermal_frame_statistics_core.sv
tb/thermal_frame_statistics_core_test.sv
